>>> hw/rtl/gls_pkg.sv
// Shared constants, types and helpers for the grid line-of-sight block.
`default_nettype none

package gls_pkg;

    localparam int MAP_SIDE  = 64;
    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int COORD_W   = 6;
    localparam int DBL_W     = COORD_W + 1;    // twice a coordinate distance
    localparam int LEFT_W    = COORD_W + 1;    // tiles left on a walk, up to 2*63+1
    localparam int ERR_W     = COORD_W + 2;    // signed error term

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic valid;
        logic visible;
    } t_walk_res;

    function automatic logic in_map(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
        in_map = (int'(x) < MAP_SIDE) && (int'(y) < MAP_SIDE);
    endfunction

    function automatic logic [ADDR_W-1:0] tile_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        tile_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(MAP_SIDE) + ADDR_W'(x));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/grid_line_of_sight.sv
// Top level of the grid line-of-sight block: handshakes, map memory, walker.
//
//  Channel  Dir  Handshake                 Payload
//  input    in   i_in_valid / o_in_stall   i_cmd, i_start_x, i_start_y, i_end_x, i_end_y,
//                                          i_clear_bit
//  output   out  o_out_valid / i_out_stall o_visible
//
// A write transaction stores its bit at the accepting edge.
// A query walks its line at the rate of one tile read per cycle of the map
// memory; a blocked line ends early.
// The output register lets a new transaction in while a result waits.
// Reset clears control state only; the map holds nothing until written.
`default_nettype none

module grid_line_of_sight (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_cmd,
    input  wire logic [gls_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [gls_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [gls_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [gls_pkg::COORD_W-1:0] i_end_y,
    input  wire logic                        i_clear_bit,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_visible
);
    import gls_pkg::*;

    logic      accept;
    logic      busy;
    logic      res_take;
    logic      rd_data;
    t_wr_req   wr;
    t_rd_req   rd;
    t_walk_res res;
    logic      r_out_valid;
    logic      r_visible;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    assign wr.en   = accept && (i_cmd == CMD_WRITE) && in_map(i_start_x, i_start_y);
    assign wr.addr = tile_addr(i_start_x, i_start_y);
    assign wr.data = i_clear_bit;

    gls_map_ram u_map (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    gls_walker u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && (i_cmd == CMD_QUERY)),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .o_busy     (busy),
        .o_rd       (rd),
        .i_rd_data  (rd_data),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // Load the result when the output register is empty or being drained.
    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_visible <= res.visible;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

endmodule

`default_nettype wire

>>> hw/rtl/gls_map_ram.sv
// Single-bit tile map memory: one write port, one registered read port.
`default_nettype none

module gls_map_ram (
    input  wire logic             i_clk,
    input  wire gls_pkg::t_wr_req i_wr,
    input  wire gls_pkg::t_rd_req i_rd,
    output logic                  o_rd_data
);
    import gls_pkg::*;

    logic r_mem [MAP_DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/gls_walker.sv
// Line walker: steps a 4-connected line, reads one tile per cycle, checks it.
`default_nettype none

module gls_walker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [gls_pkg::COORD_W-1:0]   i_start_x,
    input  wire logic [gls_pkg::COORD_W-1:0]   i_start_y,
    input  wire logic [gls_pkg::COORD_W-1:0]   i_end_x,
    input  wire logic [gls_pkg::COORD_W-1:0]   i_end_y,
    output logic                               o_busy,
    output gls_pkg::t_rd_req                   o_rd,
    input  wire logic                          i_rd_data,
    output gls_pkg::t_walk_res                 o_res,
    input  wire logic                          i_res_take
);
    import gls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [COORD_W-1:0]       r_x;
    logic [COORD_W-1:0]       r_y;
    logic                     r_x_up;
    logic                     r_y_up;
    logic [DBL_W-1:0]         r_dx2;
    logic [DBL_W-1:0]         r_dy2;
    logic signed [ERR_W-1:0]  r_err;
    logic [LEFT_W-1:0]        r_left;
    logic                     r_pend;
    logic                     r_pend_out;
    logic                     r_visible;

    logic [COORD_W-1:0]       dx;
    logic [COORD_W-1:0]       dy;
    logic                     issue;
    logic                     blocked;
    logic                     cur_in_map;

    assign dx = (i_end_x > i_start_x) ? i_end_x - i_start_x : i_start_x - i_end_x;
    assign dy = (i_end_y > i_start_y) ? i_end_y - i_start_y : i_start_y - i_end_y;

    assign cur_in_map = in_map(r_x, r_y);
    assign issue      = (r_state == S_WALK) && (r_left != '0);
    // Tile read last cycle is opaque, or lies off the map.
    assign blocked    = r_pend && (r_pend_out || !i_rd_data);

    assign o_rd.en   = issue && !blocked && cur_in_map;
    assign o_rd.addr = tile_addr(r_x, r_y);

    assign o_busy        = (r_state != S_IDLE);
    assign o_res.valid   = (r_state == S_DONE);
    assign o_res.visible = r_visible;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (i_start) begin
                        r_state <= S_WALK;
                        r_x     <= i_start_x;
                        r_y     <= i_start_y;
                        r_x_up  <= i_end_x > i_start_x;
                        r_y_up  <= i_end_y > i_start_y;
                        r_dx2   <= {dx, 1'b0};
                        r_dy2   <= {dy, 1'b0};
                        r_err   <= $signed(ERR_W'(dx)) - $signed(ERR_W'(dy));
                        r_left  <= LEFT_W'(dx) + LEFT_W'(dy) + LEFT_W'(1);
                    end
                end
                S_WALK: begin
                    if (blocked) begin
                        r_visible <= 1'b0;
                        r_pend    <= 1'b0;
                        r_state   <= S_DONE;
                    end else if (issue) begin
                        r_pend     <= 1'b1;
                        r_pend_out <= !cur_in_map;
                        r_left     <= r_left - LEFT_W'(1);
                        // Step in x on a positive error, otherwise in y.
                        if (r_err > 0) begin
                            r_x   <= r_x_up ? r_x + COORD_W'(1) : r_x - COORD_W'(1);
                            r_err <= r_err - $signed(ERR_W'(r_dy2));
                        end else begin
                            r_y   <= r_y_up ? r_y + COORD_W'(1) : r_y - COORD_W'(1);
                            r_err <= r_err + $signed(ERR_W'(r_dx2));
                        end
                    end else if (r_pend) begin
                        // Last tile checked clear; clear the pending flag before finishing.
                        r_pend <= 1'b0;
                    end else begin
                        r_visible <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
